### hw/rtl/polynomial_multiply_core_macros.svh
// Assertion macros shared by the polynomial multiply RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef POLYNOMIAL_MULTIPLY_CORE_MACROS_SVH
`define POLYNOMIAL_MULTIPLY_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMUL_ASSERT_SAME(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("pmul same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PMUL_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("pmul next-cycle check failed");

`endif

### hw/rtl/pmul_pkg.sv
// Shared constants and types for the polynomial multiply core.
// No dependencies; every other RTL file except the assertion macro header imports this package.
package pmul_pkg;

   // Largest operand degree the cell chain supports.
   localparam int MAX_DEGREE  = 15;
   localparam int STORE_DEPTH = MAX_DEGREE + 1;
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Field widths fixed by the interface.
   localparam int COEF_W    = 16;
   localparam int PROD_W    = 2 * COEF_W;
   localparam int SUM_W     = 36;
   localparam int POWER_W   = 5;
   localparam int DEGREE_W  = 4;
   localparam int COUNT_W   = 6;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_DEGREE_FIRST  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DEGREE_SECOND = 1'b1;

   // Controls broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic                     advance;
      logic                     restart;
      logic signed [COEF_W-1:0] x;
      logic signed [COEF_W-1:0] load_data;
   } pmul_ctrl_type;

endpackage

### hw/rtl/pmul_if.sv
// Valid/ready channel interfaces for the polynomial multiply core.
// Depends on pmul_pkg for the payload widths.
interface pmul_req_if;
   import pmul_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coef_in;
   modport source (output valid, output coef_in, input ready);
   modport sink (input valid, input coef_in, output ready);
endinterface

interface pmul_rsp_if;
   import pmul_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [SUM_W-1:0]   product_coef;
   logic        [POWER_W-1:0] product_power;
   logic                      last_term;
   modport source (output valid, output product_coef, output product_power,
                   output last_term, input ready);
   modport sink (input valid, input product_coef, input product_power,
                 input last_term, output ready);
endinterface

interface pmul_csr_if;
   import pmul_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [DEGREE_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/pmul_cell.sv
// One cell of the transposed convolution chain: holds one coefficient of the
// first operand and one partial sum. Depends on pmul_pkg.
module pmul_cell (
   input  logic                              clock,
   input  pmul_pkg::pmul_ctrl_type           ctrl,
   input  logic                              wr_en,
   input  logic                              active,
   input  logic signed [pmul_pkg::SUM_W-1:0] sum_in,
   output logic signed [pmul_pkg::SUM_W-1:0] sum_out
);
   import pmul_pkg::*;

   logic signed [COEF_W-1:0] coef_ff;
   logic signed [PROD_W-1:0] prod;
   logic signed [SUM_W-1:0]  term;
   logic signed [SUM_W-1:0]  carry;
   logic signed [SUM_W-1:0]  sum_in_next;
   logic signed [SUM_W-1:0]  sum_ff;

   // Coefficient is loaded once per operand load.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_ff <= ctrl.load_data;
      end
   end

   // Cells past the first operand's degree contribute nothing.
   assign prod  = coef_ff * ctrl.x;
   assign term  = active ? {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod} : '0;
   assign carry = ctrl.restart ? '0 : sum_in;
   assign sum_in_next = term + carry;

   // The partial sum moves one cell toward the output on each step.
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         sum_ff <= sum_in_next;
      end
   end

   assign sum_out = sum_ff;

endmodule

### hw/rtl/pmul_seq.sv
// Sequencer of the polynomial multiply core: configuration registers, load
// counter, second operand store and the emission counter. Depends on pmul_pkg
// and the assertion macros.
`include "polynomial_multiply_core_macros.svh"

module pmul_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pmul_pkg::COEF_W-1:0]   coef_in,
   input  logic                                 csr_valid,
   input  logic [pmul_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pmul_pkg::DEGREE_W-1:0]        csr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [pmul_pkg::POWER_W-1:0]         product_power,
   output logic                                 last_term,
   output pmul_pkg::pmul_ctrl_type              ctrl,
   output logic                                 a_wr,
   output logic [pmul_pkg::IDX_W-1:0]           a_idx,
   output logic [pmul_pkg::IDX_W-1:0]           deg_first
);
   import pmul_pkg::*;

   function automatic logic [IDX_W-1:0] clip_degree(input logic [DEGREE_W-1:0] d);
      logic [IDX_W-1:0] r;
      if (int'(d) > MAX_DEGREE) begin
         r = IDX_W'(MAX_DEGREE);
      end else begin
         r = IDX_W'(d);
      end
      return r;
   endfunction

   logic [DEGREE_W-1:0]      degree_first_ff, degree_second_ff;
   logic [IDX_W-1:0]         da, db;
   logic [COUNT_W-1:0]       na, total, cnt, cnt_next, b_off;
   logic [COUNT_W-1:0]       load_count_ff, load_count_in;
   logic                     emit_ff, emit_in;
   logic [POWER_W-1:0]       k_ff, k_in, kmax;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [POWER_W-1:0]       power_ff;
   logic                     last_ff;
   logic                     accept, load_done, advance;
   logic signed [COEF_W-1:0] second_store_ff [STORE_DEPTH];
   logic signed [COEF_W-1:0] x;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_first_ff  <= '0;
         degree_second_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_DEGREE_FIRST:  degree_first_ff  <= csr_data;
            REG_DEGREE_SECOND: degree_second_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign da        = clip_degree(degree_first_ff);
   assign db        = clip_degree(degree_second_ff);
   assign deg_first = da;
   assign kmax      = POWER_W'(da) + POWER_W'(db);

   // Load position; a count at or beyond the current total restarts the load.
   assign na       = COUNT_W'(da) + COUNT_W'(1);
   assign total    = na + COUNT_W'(db) + COUNT_W'(1);
   assign cnt      = (load_count_ff >= total) ? '0 : load_count_ff;
   assign cnt_next = cnt + COUNT_W'(1);
   assign b_off    = cnt - na;

   assign req_ready = !emit_ff;
   assign accept    = req_valid && req_ready;
   assign load_done = accept && (cnt_next == total);
   assign a_wr      = accept && (cnt < na);
   assign a_idx     = cnt[IDX_W-1:0];

   // Second operand store.
   always_ff @(posedge clock) begin
      if (accept && (cnt >= na)) begin
         second_store_ff[b_off[IDX_W-1:0]] <= coef_in;
      end
   end

   // The chain steps only when the output register is free or being taken.
   assign advance = emit_ff && (!rsp_valid_ff || rsp_ready);
   assign x = (k_ff <= POWER_W'(db)) ? second_store_ff[k_ff[IDX_W-1:0]] : '0;

   assign ctrl.advance   = advance;
   assign ctrl.restart   = (k_ff == '0);
   assign ctrl.x         = x;
   assign ctrl.load_data = coef_in;

   // Next-state logic for load and emission.
   always_comb begin
      load_count_in = load_count_ff;
      emit_in       = emit_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (accept) begin
         load_count_in = load_done ? '0 : cnt_next;
      end
      if (load_done) begin
         emit_in = 1'b1;
         k_in    = '0;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         k_in         = k_ff + POWER_W'(1);
         if (k_ff == kmax) begin
            emit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         emit_ff       <= 1'b0;
         k_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         emit_ff       <= emit_in;
         k_ff          <= k_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Term index and last marker travel with the chain's output sum.
   always_ff @(posedge clock) begin
      if (advance) begin
         power_ff <= k_ff;
         last_ff  <= (k_ff == kmax);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign product_power = power_ff;
   assign last_term     = last_ff;

   // A completed load starts emission from the lowest term.
   `PMUL_ASSERT_NEXT(a_load_starts_emit, load_done, emit_ff && load_count_ff == '0 && k_ff == '0)
   // Emission stops right after the highest term is computed.
   `PMUL_ASSERT_NEXT(a_emit_stops, advance && k_ff == kmax, !emit_ff)
   // The last marker is set exactly on the highest term.
   `PMUL_ASSERT_NEXT(a_last_marks_top, advance, rsp_valid_ff && (last_ff == (power_ff == $past(kmax))))

endmodule

### hw/rtl/polynomial_multiply_core.sv
// Top level of the polynomial multiply core: sequencer plus a chain of cells.
// Depends on pmul_pkg, pmul_if, pmul_cell and pmul_seq.
//
// Usage: write degree_first (index 0) and degree_second (index 1) on the csr
// channel, then send the first operand's degree_first+1 coefficients and the
// second operand's degree_second+1 coefficients on req, lowest degree first,
// as signed Q8.8, one per beat. Once the last coefficient is accepted, the
// emission flag is set and the chain's first step registers the lowest term;
// then rsp delivers the degree_first+degree_second+1 product coefficients in
// signed Q20.16, lowest degree first, one per cycle while rsp is not stalled,
// with last_term on the highest degree. The cell chain advances one step per
// product term, and req is not ready while the chain is emitting, so the next
// product's load waits until emission ends.
// When the receiver stalls, the chain holds its state and the pending beat
// stays on rsp; the next load may still proceed while the last beat waits.
// Reset clears the degrees to zero, the load counter and all valid flags;
// stored coefficients are not cleared and are defined once loaded.
module polynomial_multiply_core (
   input  logic           clock,
   input  logic           reset,
   pmul_req_if.sink       req_if,
   pmul_rsp_if.source     rsp_if,
   pmul_csr_if.sink       csr_if
);
   import pmul_pkg::*;

   pmul_ctrl_type           ctrl;
   logic                    a_wr;
   logic [IDX_W-1:0]        a_idx;
   logic [IDX_W-1:0]        deg_first;
   logic signed [SUM_W-1:0] chain_sum [STORE_DEPTH+1];

   assign csr_if.ready = 1'b1;

   pmul_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .coef_in       (req_if.coef_in),
      .csr_valid     (csr_if.valid),
      .csr_index     (csr_if.index),
      .csr_data      (csr_if.data),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .product_power (rsp_if.product_power),
      .last_term     (rsp_if.last_term),
      .ctrl          (ctrl),
      .a_wr          (a_wr),
      .a_idx         (a_idx),
      .deg_first     (deg_first)
   );

   // The far end of the chain feeds a zero partial sum.
   assign chain_sum[STORE_DEPTH] = '0;

   // Cell i holds coefficient i of the first operand.
   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      pmul_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .wr_en   (a_wr && (a_idx == IDX_W'(i))),
         .active  (IDX_W'(i) <= deg_first),
         .sum_in  (chain_sum[i+1]),
         .sum_out (chain_sum[i])
      );
   end

   assign rsp_if.product_coef = chain_sum[0];

endmodule

### tb/tb_top.sv
// Self-checking testbench for polynomial_multiply_core (coefficient convolution).
// Depends on pmul_pkg, the pmul_*_if interfaces and the core's RTL files.
// A built-in predictor convolves the loaded operands and checks every product beat.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pmul_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 2000000;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned TARGET_COEFS  = 430;
   localparam int unsigned MAX_PRINTED   = 40;

   // One expected product term.
   typedef struct packed {
      logic signed [SUM_W-1:0] coef;
      logic [POWER_W-1:0]      power;
      logic                    last_term;
   } term_type;

   logic clock = 1'b0;
   logic reset;

   pmul_req_if req_if ();
   pmul_rsp_if rsp_if ();
   pmul_csr_if csr_if ();

   polynomial_multiply_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: the operand stores, the load position and the degrees.
   logic signed [COEF_W-1:0] first_coefs [STORE_DEPTH];
   logic signed [COEF_W-1:0] second_coefs [STORE_DEPTH];
   int unsigned              coef_count = 0;
   logic [DEGREE_W-1:0]      cfg_first = '0;
   logic [DEGREE_W-1:0]      cfg_second = '0;

   term_type                 expected_terms [$];
   logic signed [COEF_W-1:0] coef_q [$];

   int unsigned req_pushed = 0;
   int unsigned req_sent = 0;
   int unsigned req_done = 0;
   int unsigned rsp_done = 0;
   int unsigned rsp_seen = 0;
   int unsigned products_seen = 0;
   int unsigned settings_used = 0;
   int unsigned err_count = 0;
   int unsigned cycles = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   bit          req_busy = 1'b0;
   bit          no_idle = 1'b0;

   task automatic report_mismatch(input string what);
      if (err_count < MAX_PRINTED)
         $display("[%0t] mismatch: %s", $realtime, what);
      err_count++;
   endtask

   function automatic int unsigned draw_wait();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   // Store one coefficient; on the last one of the second operand, queue the
   // full convolution, lowest degree first.
   task automatic convolve_coef(input logic signed [COEF_W-1:0] c);
      int unsigned da, db, na, total, cnt;
      longint      acc;
      term_type    t;
      da = (cfg_first > MAX_DEGREE) ? MAX_DEGREE : cfg_first;
      db = (cfg_second > MAX_DEGREE) ? MAX_DEGREE : cfg_second;
      na = da + 1;
      total = na + db + 1;
      cnt = coef_count;
      // A load at or past the current total count starts over with the first operand.
      if (cnt >= total)
         cnt = 0;
      if (cnt < na)
         first_coefs[cnt] = c;
      else
         second_coefs[cnt - na] = c;
      cnt++;
      if (cnt < total) begin
         coef_count = cnt;
         return;
      end
      coef_count = 0;
      for (int unsigned k = 0; k <= da + db; k++) begin
         acc = 0;
         for (int unsigned i = 0; i <= da; i++) begin
            if (k >= i && k - i <= db)
               acc += longint'(first_coefs[i]) * longint'(second_coefs[k - i]);
         end
         t.coef = acc[SUM_W-1:0];
         t.power = k[POWER_W-1:0];
         t.last_term = (k == da + db);
         expected_terms.push_back(t);
      end
   endtask

   // Input driver: one coefficient per beat, with a random gap before each.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_busy && req_done == req_sent) begin
            req_busy = 1'b0;
            req_gap = draw_wait();
         end
         if (!req_busy) begin
            if (req_gap != 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (coef_q.size() != 0) begin
               req_if.coef_in <= coef_q.pop_front();
               req_if.valid <= 1'b1;
               req_sent++;
               req_busy = 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result sink: a random stall after each accepted beat.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_seen != rsp_done) begin
            rsp_seen = rsp_done;
            rsp_stall = draw_wait();
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Monitor: feed accepted coefficients to the predictor and check each
   // accepted product beat against the oldest expected term.
   always @(posedge clock) begin
      term_type want;
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[%0t] timeout after %0d cycles", $realtime, cycles);
         $display("tb: failure");
         $finish;
      end else if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_done++;
            convolve_coef(req_if.coef_in);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_done++;
            if (rsp_if.last_term)
               products_seen++;
            if (expected_terms.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, power %0d coef %0d",
                                         rsp_if.product_power, rsp_if.product_coef));
            end else begin
               want = expected_terms.pop_front();
               if (rsp_if.product_coef !== want.coef)
                  report_mismatch($sformatf("power %0d: coef %0d, expected %0d",
                                            want.power, rsp_if.product_coef, want.coef));
               if (rsp_if.product_power !== want.power)
                  report_mismatch($sformatf("power %0d, expected %0d",
                                            rsp_if.product_power, want.power));
               if (rsp_if.last_term !== want.last_term)
                  report_mismatch($sformatf("power %0d: last_term %0b, expected %0b",
                                            want.power, rsp_if.last_term, want.last_term));
            end
         end
      end
   end

   function automatic logic signed [COEF_W-1:0] rand_coef();
      case ($urandom_range(0, 9))
         0:       return -16'sd32768;
         1:       return 16'sd32767;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   task automatic push_coef(input logic signed [COEF_W-1:0] c);
      coef_q.push_back(c);
      req_pushed++;
   endtask

   // Register write over the csr channel; the block is idle when this runs.
   task automatic write_degree(input logic [CSR_IDX_W-1:0] idx,
                               input logic [DEGREE_W-1:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      do
         @(posedge clock);
      while (!csr_if.ready);
      if (idx == REG_DEGREE_FIRST)
         cfg_first = val;
      else
         cfg_second = val;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_degrees(input logic [DEGREE_W-1:0] df, input logic [DEGREE_W-1:0] ds);
      if ($urandom_range(0, 1)) begin
         write_degree(REG_DEGREE_FIRST, df);
         write_degree(REG_DEGREE_SECOND, ds);
      end else begin
         write_degree(REG_DEGREE_SECOND, ds);
         write_degree(REG_DEGREE_FIRST, df);
      end
      settings_used++;
   endtask

   // Wait until every coefficient is in and every term is out. A load left
   // half done gets extra cycles before the degrees may change.
   task automatic wait_idle();
      while (req_done != req_pushed || expected_terms.size() != 0)
         @(negedge clock);
      if (coef_count != 0)
         repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_product();
      int unsigned n;
      n = cfg_first + cfg_second + 2;
      repeat (n) push_coef(rand_coef());
   endtask

   initial begin
      int unsigned r, total;
      logic [DEGREE_W-1:0] df, ds;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.coef_in = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_DEGREE_FIRST;
      csr_if.data = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Constant polynomials with the most negative and most positive values.
      set_degrees(4'd0, 4'd0);
      push_coef(-16'sd32768);
      push_coef(-16'sd32768);
      push_coef(16'sd32767);
      push_coef(-16'sd32768);
      wait_idle();

      // Highest first degree against a constant, alternating bit patterns.
      set_degrees(4'd15, 4'd0);
      for (int i = 0; i < STORE_DEPTH; i++) begin
         case (i % 4)
            0:       push_coef(16'sd32767);
            1:       push_coef(-16'sd32768);
            2:       push_coef(16'sh5555);
            default: push_coef(16'shAAAA);
         endcase
      end
      push_coef(-16'sd32768);
      wait_idle();

      // Lower the degrees in the middle of a load: the load starts over.
      set_degrees(4'd1, 4'd1);
      repeat (3) push_coef(rand_coef());
      wait_idle();
      set_degrees(4'd0, 4'd0);
      push_coef(16'sh0180);
      push_coef(-16'sh0040);
      wait_idle();

      // Both degrees at their top with the most negative coefficient gives the
      // largest sum; it also fills every store entry before the random part.
      set_degrees(4'd15, 4'd15);
      repeat (2 * STORE_DEPTH) push_coef(-16'sd32768);
      wait_idle();

      // Random phases: mostly whole products, now and then a load cut short.
      while (req_pushed < TARGET_COEFS) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            df = DEGREE_W'($urandom_range(0, 3));
            ds = DEGREE_W'($urandom_range(0, 3));
         end else if (r < 9) begin
            df = DEGREE_W'($urandom_range(0, 15));
            ds = DEGREE_W'($urandom_range(0, 15));
         end else begin
            df = 4'd15;
            ds = $urandom_range(0, 1) ? 4'd15 : 4'd0;
         end
         set_degrees(df, ds);
         no_idle = ($urandom_range(0, 3) == 0);
         total = df + ds + 2;
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, total - 1)) push_coef(rand_coef());
         end else begin
            repeat ($urandom_range(1, 3)) push_product();
         end
         wait_idle();
      end

      no_idle = 1'b0;
      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_terms.size() != 0)
         report_mismatch($sformatf("%0d expected terms never came", expected_terms.size()));

      $display("summary: %0d coefficients in, %0d terms checked, %0d products, %0d degree settings",
               req_done, rsp_done, products_seen, settings_used);
      $display("summary: %0d mismatches in %0d cycles", err_count, cycles);
      if (err_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pmul_pkg.sv
hw/rtl/pmul_if.sv
hw/rtl/pmul_cell.sv
hw/rtl/pmul_seq.sv
hw/rtl/polynomial_multiply_core.sv
tb/tb_top.sv
